// ----- rtl/prt_pkg.sv -----
// prt_pkg: shared types, codes and widths for the pending request tracker
// no dependencies; imported by every module of the block but prt_ram
`timescale 1ns / 1ps
`default_nettype none

package prt_pkg;

  localparam int SLOTS_DEFAULT = 8;
  localparam int BYTE_W        = 8;
  localparam int CFG_IDX_W     = 3;
  localparam int CONN_W        = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_MAX_TAG      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CODE_LIVE    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CODE_CONNECT = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_CODE_DATA    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_CODE_ACK     = 3'd4;

  localparam logic [BYTE_W-1:0] RST_MAX_TAG      = 8'd255;
  localparam logic [BYTE_W-1:0] RST_CODE_LIVE    = 8'd1;
  localparam logic [BYTE_W-1:0] RST_CODE_CONNECT = 8'd2;
  localparam logic [BYTE_W-1:0] RST_CODE_DATA    = 8'd3;
  localparam logic [BYTE_W-1:0] RST_CODE_ACK     = 8'd4;

  localparam logic FUNC_SEND = 1'b0;
  localparam logic FUNC_RECV = 1'b1;

  localparam logic [CONN_W-1:0] CONN_NONE      = 2'd0;
  localparam logic [CONN_W-1:0] CONN_SET       = 2'd1;
  localparam logic [CONN_W-1:0] CONN_NOT_READY = 2'd2;

  typedef struct packed {
    logic [BYTE_W-1:0] cmd;
    logic [BYTE_W-1:0] src;
    logic [BYTE_W-1:0] peer;
    logic [BYTE_W-1:0] tag;
    logic [BYTE_W-1:0] retries;
  } prt_entry_t;

  localparam int ENTRY_W = $bits(prt_entry_t);

  typedef struct packed {
    logic start;
    logic walk;
    logic commit;
  } prt_cmd_t;

  typedef struct packed {
    logic walk_done;
    logic out_busy;
  } prt_sts_t;

endpackage

`default_nettype wire

// ----- rtl/pending_request_tracker.sv -----
// pending_request_tracker: top level, joins the sequencer and the datapath
// depends on prt_pkg, prt_ctrl and prt_datapath
`timescale 1ns / 1ps
`default_nettype none

// Builds outgoing message headers and tracks up to SLOTS requests awaiting a
// reply. One transaction is processed at a time: an accept, a walk over the
// slot table at one entry per cycle behind the registered read of the slot
// memory, ending early when a matching slot is found, and a commit, which
// waits while a previous result is held at the output. The result register
// lets the next item be accepted and walked while the previous result waits
// at the output. Slot valid bits are flip-flops cleared by reset, so no
// clearing pass is needed.
module pending_request_tracker #(
  parameter int SLOTS = prt_pkg::SLOTS_DEFAULT
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic                          func,
  input  wire logic [prt_pkg::BYTE_W-1:0]    cmd,
  input  wire logic [prt_pkg::BYTE_W-1:0]    src_addr,
  input  wire logic [prt_pkg::BYTE_W-1:0]    dst_addr,
  input  wire logic [prt_pkg::BYTE_W-1:0]    tag,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic [prt_pkg::BYTE_W-1:0]         hdr_cmd,
  output logic [prt_pkg::BYTE_W-1:0]         hdr_src,
  output logic [prt_pkg::BYTE_W-1:0]         hdr_dst,
  output logic [prt_pkg::BYTE_W-1:0]         hdr_tag,
  output logic [prt_pkg::BYTE_W-1:0]         wait_tag,
  output logic                               table_full,
  output logic                               user_notify,
  output logic [prt_pkg::CONN_W-1:0]         conn_update,
  output logic [prt_pkg::BYTE_W-1:0]         conn_local,
  output logic [prt_pkg::BYTE_W-1:0]         conn_peer,
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [prt_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [prt_pkg::BYTE_W-1:0]    cfg_data
);
  import prt_pkg::*;

  prt_cmd_t ctl_cmd;
  prt_sts_t dp_sts;

  assign cfg_ready = 1'b1;

  prt_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .sts     (dp_sts),
    .cmd_o   (ctl_cmd)
  );

  prt_datapath #(
    .SLOTS(SLOTS)
  ) u_datapath (
    .clk        (clk),
    .rst        (rst),
    .cmd_i      (ctl_cmd),
    .sts        (dp_sts),
    .cfg_we     (cfg_valid && cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .func       (func),
    .cmd        (cmd),
    .src_addr   (src_addr),
    .dst_addr   (dst_addr),
    .tag        (tag),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .hdr_cmd    (hdr_cmd),
    .hdr_src    (hdr_src),
    .hdr_dst    (hdr_dst),
    .hdr_tag    (hdr_tag),
    .wait_tag   (wait_tag),
    .table_full (table_full),
    .user_notify(user_notify),
    .conn_update(conn_update),
    .conn_local (conn_local),
    .conn_peer  (conn_peer)
  );

endmodule

`default_nettype wire

// ----- rtl/prt_ram.sv -----
// prt_ram: generic single write port ram with registered read
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

module prt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [ADDR_W-1:0] waddr,
  input  wire logic [WIDTH-1:0]  wdata,
  input  wire logic [ADDR_W-1:0] raddr,
  output logic      [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ----- rtl/prt_ctrl.sv -----
// prt_ctrl: sequencer for accept, slot walk and commit
// depends on prt_pkg for the command and status structs
`timescale 1ns / 1ps
`default_nettype none

module prt_ctrl (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire prt_pkg::prt_sts_t sts,
  output prt_pkg::prt_cmd_t      cmd_o
);
  import prt_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_WALK,
    S_COMMIT
  } state_t;

  state_t state;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_valid) state <= S_WALK;
        end
        S_WALK: begin
          if (sts.walk_done) state <= S_COMMIT;
        end
        S_COMMIT: begin
          if (!sts.out_busy) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign in_stall     = (state != S_IDLE);
  assign cmd_o.start  = (state == S_IDLE) && in_valid;
  assign cmd_o.walk   = (state == S_WALK);
  assign cmd_o.commit = (state == S_COMMIT) && !sts.out_busy;

endmodule

`default_nettype wire

// ----- rtl/prt_datapath.sv -----
// prt_datapath: config registers, tag counter, slot table, walk compare and result register
// depends on prt_pkg and prt_ram
`timescale 1ns / 1ps
`default_nettype none

module prt_datapath #(
  parameter int SLOTS = prt_pkg::SLOTS_DEFAULT
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire prt_pkg::prt_cmd_t             cmd_i,
  output prt_pkg::prt_sts_t                  sts,
  input  wire logic                          cfg_we,
  input  wire logic [prt_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [prt_pkg::BYTE_W-1:0]    cfg_data,
  input  wire logic                          func,
  input  wire logic [prt_pkg::BYTE_W-1:0]    cmd,
  input  wire logic [prt_pkg::BYTE_W-1:0]    src_addr,
  input  wire logic [prt_pkg::BYTE_W-1:0]    dst_addr,
  input  wire logic [prt_pkg::BYTE_W-1:0]    tag,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic [prt_pkg::BYTE_W-1:0]         hdr_cmd,
  output logic [prt_pkg::BYTE_W-1:0]         hdr_src,
  output logic [prt_pkg::BYTE_W-1:0]         hdr_dst,
  output logic [prt_pkg::BYTE_W-1:0]         hdr_tag,
  output logic [prt_pkg::BYTE_W-1:0]         wait_tag,
  output logic                               table_full,
  output logic                               user_notify,
  output logic [prt_pkg::CONN_W-1:0]         conn_update,
  output logic [prt_pkg::BYTE_W-1:0]         conn_local,
  output logic [prt_pkg::BYTE_W-1:0]         conn_peer
);
  import prt_pkg::*;

  localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CNT_W = IDX_W + 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOTS - 1);
  localparam logic [CNT_W-1:0] SLOTS_CNT = CNT_W'(SLOTS);

  logic [BYTE_W-1:0] max_tag, code_live, code_connect, code_data, code_ack;
  logic [BYTE_W-1:0] tag_counter;

  logic              in_func;
  logic [BYTE_W-1:0] in_cmd, in_src, in_dst, in_tag;

  logic [SLOTS-1:0]  slot_valid;
  logic [CNT_W-1:0]  rd_idx;
  logic              data_ok;
  logic [IDX_W-1:0]  data_idx;
  logic              hit_found, free_found;
  logic [IDX_W-1:0]  hit_idx, free_idx;
  prt_entry_t        hit_data;

  prt_entry_t        rd_data;
  logic [ENTRY_W-1:0] rd_raw;
  logic              reusable, expect_reply, send_match, recv_match, hit_now;

  logic              wr_en;
  logic [IDX_W-1:0]  wr_addr;
  prt_entry_t        wr_data;
  logic              set_valid, clr_valid, full_now, match_ok;
  logic              notify_now;
  logic [CONN_W-1:0] upd_now;
  logic [BYTE_W-1:0] loc_now, peer_now;

  prt_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (SLOTS),
    .ADDR_W(IDX_W)
  ) u_slot_ram (
    .clk  (clk),
    .we   (wr_en),
    .waddr(wr_addr),
    .wdata(wr_data),
    .raddr(rd_idx[IDX_W-1:0]),
    .rdata(rd_raw)
  );

  assign rd_data = prt_entry_t'(rd_raw);

  // config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      max_tag      <= RST_MAX_TAG;
      code_live    <= RST_CODE_LIVE;
      code_connect <= RST_CODE_CONNECT;
      code_data    <= RST_CODE_DATA;
      code_ack     <= RST_CODE_ACK;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_MAX_TAG:      max_tag      <= cfg_data;
        CFG_CODE_LIVE:    code_live    <= cfg_data;
        CFG_CODE_CONNECT: code_connect <= cfg_data;
        CFG_CODE_DATA:    code_data    <= cfg_data;
        CFG_CODE_ACK:     code_ack     <= cfg_data;
        default: ;
      endcase
    end
  end

  // tag counter advances when a send with a zero tag is accepted, wrapping to zero after max_tag
  always_ff @(posedge clk) begin
    if (rst) begin
      tag_counter <= '0;
    end else if (cmd_i.start && func == FUNC_SEND && tag == '0) begin
      tag_counter <= (tag_counter < max_tag) ? tag_counter + 8'd1 : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_i.start) begin
      in_func <= func;
      in_cmd  <= cmd;
      in_src  <= src_addr;
      in_dst  <= dst_addr;
      in_tag  <= tag;
    end
  end

  assign reusable     = (in_cmd == code_live) || (in_cmd == code_connect);
  assign expect_reply = reusable || (in_cmd == code_data);
  assign send_match   = reusable && (rd_data.cmd == in_cmd) &&
                        (rd_data.src == in_src) && (rd_data.peer == in_dst);
  assign recv_match   = (rd_data.tag == in_tag);
  assign hit_now      = data_ok && slot_valid[data_idx] &&
                        ((in_func == FUNC_SEND) ? send_match : recv_match);

  assign sts.walk_done = cmd_i.walk && data_ok && (hit_now || data_idx == LAST_IDX);
  assign sts.out_busy  = out_valid && out_stall;

  // slot walk, one entry per cycle behind the registered read
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_idx     <= '0;
      data_ok    <= 1'b0;
      hit_found  <= 1'b0;
      free_found <= 1'b0;
    end else if (cmd_i.start) begin
      rd_idx     <= '0;
      data_ok    <= 1'b0;
      hit_found  <= 1'b0;
      free_found <= 1'b0;
    end else if (cmd_i.walk) begin
      data_ok  <= (rd_idx < SLOTS_CNT);
      data_idx <= rd_idx[IDX_W-1:0];
      if (rd_idx < SLOTS_CNT) rd_idx <= rd_idx + CNT_W'(1);
      if (data_ok && !hit_found) begin
        if (hit_now) begin
          hit_found <= 1'b1;
          hit_idx   <= data_idx;
          hit_data  <= rd_data;
        end
        if (!free_found && !slot_valid[data_idx]) begin
          free_found <= 1'b1;
          free_idx   <= data_idx;
        end
      end
    end
  end

  assign match_ok = hit_found && (hit_data.peer == in_src);

  always_comb begin
    wr_en      = 1'b0;
    wr_addr    = hit_idx;
    wr_data    = hit_data;
    set_valid  = 1'b0;
    clr_valid  = 1'b0;
    full_now   = 1'b0;
    notify_now = 1'b0;
    upd_now    = CONN_NONE;
    loc_now    = '0;
    peer_now   = '0;
    if (in_func == FUNC_SEND) begin
      if (expect_reply) begin
        if (hit_found) begin
          wr_en           = 1'b1;
          wr_data.tag     = tag_counter;
          wr_data.retries = hit_data.retries + 8'd1;
        end else if (free_found) begin
          wr_en     = 1'b1;
          set_valid = 1'b1;
          wr_addr   = free_idx;
          wr_data   = '{cmd: in_cmd, src: in_src, peer: in_dst,
                        tag: tag_counter, retries: '0};
        end else begin
          full_now = 1'b1;
        end
      end
    end else if (match_ok) begin
      clr_valid = 1'b1;
      if (hit_data.cmd == code_connect) begin
        upd_now  = (in_cmd == code_ack) ? CONN_SET : CONN_NOT_READY;
        loc_now  = hit_data.src;
        peer_now = hit_data.peer;
      end else if (hit_data.cmd == code_live) begin
        if (in_cmd != code_ack) begin
          upd_now  = CONN_NOT_READY;
          loc_now  = hit_data.src;
          peer_now = hit_data.peer;
        end
      end else begin
        notify_now = 1'b1;
      end
    end
    wr_en = wr_en && cmd_i.commit;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slot_valid <= '0;
    end else if (cmd_i.commit) begin
      if (set_valid) slot_valid[free_idx] <= 1'b1;
      if (clr_valid) slot_valid[hit_idx] <= 1'b0;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd_i.commit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_i.commit) begin
      if (in_func == FUNC_SEND) begin
        hdr_cmd  <= in_cmd;
        hdr_src  <= in_src;
        hdr_dst  <= in_dst;
        hdr_tag  <= (in_tag == '0) ? tag_counter : in_tag;
        wait_tag <= expect_reply ? tag_counter : '0;
      end else begin
        hdr_cmd  <= '0;
        hdr_src  <= '0;
        hdr_dst  <= '0;
        hdr_tag  <= '0;
        wait_tag <= '0;
      end
      table_full  <= full_now;
      user_notify <= notify_now;
      conn_update <= upd_now;
      conn_local  <= loc_now;
      conn_peer   <= peer_now;
    end
  end

  a_commit_needs_room: assert property (@(posedge clk) disable iff (rst)
    cmd_i.commit |-> !(out_valid && out_stall))
    else $error("result committed over a pending result");

  a_full_only_when_full: assert property (@(posedge clk) disable iff (rst)
    (cmd_i.commit && in_func == FUNC_SEND && full_now) |-> (&slot_valid))
    else $error("table full reported with a free slot");

  a_reply_frees_slot: assert property (@(posedge clk) disable iff (rst)
    (cmd_i.commit && clr_valid) |=> !slot_valid[$past(hit_idx)])
    else $error("matched reply left its slot valid");

endmodule

`default_nettype wire

// ----- test/tb_top.sv -----
// tb_top: self-checking testbench for pending_request_tracker
// depends on prt_pkg and the pending_request_tracker rtl; a clocked driver and monitor
// run against a local model of the slot table, with directed and random traffic
`timescale 1ns / 1ps

module tb_top;
  import prt_pkg::*;

  localparam int SLOTS = SLOTS_DEFAULT;
  localparam int LIMIT = 300000;
  localparam int MAX_PRINTS = 200;

  typedef struct packed {
    logic              func;
    logic [BYTE_W-1:0] cmd;
    logic [BYTE_W-1:0] src;
    logic [BYTE_W-1:0] dst;
    logic [BYTE_W-1:0] tag;
  } msg_t;

  typedef struct packed {
    logic [BYTE_W-1:0] hdr_cmd;
    logic [BYTE_W-1:0] hdr_src;
    logic [BYTE_W-1:0] hdr_dst;
    logic [BYTE_W-1:0] hdr_tag;
    logic [BYTE_W-1:0] wait_tag;
    logic              table_full;
    logic              user_notify;
    logic [CONN_W-1:0] conn_update;
    logic [BYTE_W-1:0] conn_local;
    logic [BYTE_W-1:0] conn_peer;
  } outcome_t;

  typedef struct packed {
    logic [BYTE_W-1:0] max_tag;
    logic [BYTE_W-1:0] live;
    logic [BYTE_W-1:0] connect;
    logic [BYTE_W-1:0] data;
    logic [BYTE_W-1:0] ack;
  } codes_t;

  typedef struct packed {
    logic [BYTE_W-1:0]           tag_ctr;
    logic [SLOTS-1:0]            valid;
    prt_entry_t [SLOTS-1:0]      entry;
  } table_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic func = 1'b0;
  logic [BYTE_W-1:0] cmd = '0;
  logic [BYTE_W-1:0] src_addr = '0;
  logic [BYTE_W-1:0] dst_addr = '0;
  logic [BYTE_W-1:0] tag = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [BYTE_W-1:0] hdr_cmd, hdr_src, hdr_dst, hdr_tag, wait_tag;
  logic table_full, user_notify;
  logic [CONN_W-1:0] conn_update;
  logic [BYTE_W-1:0] conn_local, conn_peer;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [BYTE_W-1:0] cfg_data = '0;

  codes_t codes = {RST_MAX_TAG, RST_CODE_LIVE, RST_CODE_CONNECT, RST_CODE_DATA, RST_CODE_ACK};
  table_t gen_table = '0;
  table_t chk_table = '0;
  msg_t msg_q[$];
  outcome_t outcome_q[$];
  int queued = 0;
  int accepted = 0;
  int errors = 0;
  int cycles = 0;
  int send_idle_pct = 15;
  int recv_stall_pct = 64;
  bit in_fire = 1'b0;

  pending_request_tracker #(.SLOTS(SLOTS)) uut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .func(func), .cmd(cmd), .src_addr(src_addr), .dst_addr(dst_addr), .tag(tag),
    .out_valid(out_valid), .out_stall(out_stall),
    .hdr_cmd(hdr_cmd), .hdr_src(hdr_src), .hdr_dst(hdr_dst), .hdr_tag(hdr_tag),
    .wait_tag(wait_tag), .table_full(table_full), .user_notify(user_notify),
    .conn_update(conn_update), .conn_local(conn_local), .conn_peer(conn_peer),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #4 clk = ~clk;

  // next table state and header outcome for one message
  function automatic table_t track_msg(input table_t st, input msg_t m, output outcome_t o);
    int hit;
    int i;
    logic reuse;
    logic waits;
    o = '0;
    hit = -1;
    if (m.func == FUNC_SEND) begin
      reuse = (m.cmd == codes.live) || (m.cmd == codes.connect);
      waits = reuse || (m.cmd == codes.data);
      if (m.tag == '0) begin
        st.tag_ctr = (st.tag_ctr < codes.max_tag) ? st.tag_ctr + 8'd1 : '0;
      end
      if (waits) begin
        if (reuse) begin
          for (i = 0; i < SLOTS; i++) begin
            if (hit < 0 && st.valid[i] && st.entry[i].cmd == m.cmd &&
                st.entry[i].src == m.src && st.entry[i].peer == m.dst) begin
              hit = i;
            end
          end
        end
        if (hit >= 0) begin
          st.entry[hit].tag = st.tag_ctr;
          st.entry[hit].retries = st.entry[hit].retries + 8'd1;
        end else begin
          for (i = 0; i < SLOTS; i++) begin
            if (hit < 0 && !st.valid[i]) begin
              hit = i;
            end
          end
          if (hit >= 0) begin
            st.valid[hit] = 1'b1;
            st.entry[hit] = {m.cmd, m.src, m.dst, st.tag_ctr, 8'd0};
          end else begin
            o.table_full = 1'b1;
          end
        end
        o.wait_tag = st.tag_ctr;
      end
      o.hdr_cmd = m.cmd;
      o.hdr_src = m.src;
      o.hdr_dst = m.dst;
      o.hdr_tag = (m.tag == '0) ? st.tag_ctr : m.tag;
    end else begin
      for (i = 0; i < SLOTS; i++) begin
        if (hit < 0 && st.valid[i] && st.entry[i].tag == m.tag) begin
          hit = i;
        end
      end
      if (hit >= 0 && st.entry[hit].peer == m.src) begin
        if (st.entry[hit].cmd == codes.connect) begin
          o.conn_update = (m.cmd == codes.ack) ? CONN_SET : CONN_NOT_READY;
          o.conn_local = st.entry[hit].src;
          o.conn_peer = st.entry[hit].peer;
        end else if (st.entry[hit].cmd == codes.live) begin
          if (m.cmd != codes.ack) begin
            o.conn_update = CONN_NOT_READY;
            o.conn_local = st.entry[hit].src;
            o.conn_peer = st.entry[hit].peer;
          end
        end else begin
          o.user_notify = 1'b1;
        end
        st.valid[hit] = 1'b0;
      end
    end
    return st;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    if (errors < MAX_PRINTS) begin
      $display("tb: %s mismatch at cycle %0d, got %0h want %0h", what, cycles, got, want);
    end
    errors++;
  endtask

  task automatic queue_msg(logic f, logic [BYTE_W-1:0] c, logic [BYTE_W-1:0] s,
                           logic [BYTE_W-1:0] d, logic [BYTE_W-1:0] t);
    msg_t m;
    outcome_t scratch;
    m = {f, c, s, d, t};
    gen_table = track_msg(gen_table, m, scratch);
    msg_q.push_back(m);
    queued++;
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [BYTE_W-1:0] value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_MAX_TAG:      codes.max_tag = value;
      CFG_CODE_LIVE:    codes.live = value;
      CFG_CODE_CONNECT: codes.connect = value;
      CFG_CODE_DATA:    codes.data = value;
      CFG_CODE_ACK:     codes.ack = value;
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic write_codes(logic [BYTE_W-1:0] mt, logic [BYTE_W-1:0] lv,
                             logic [BYTE_W-1:0] cn, logic [BYTE_W-1:0] dt,
                             logic [BYTE_W-1:0] ak);
    write_reg(CFG_MAX_TAG, mt);
    write_reg(CFG_CODE_LIVE, lv);
    write_reg(CFG_CODE_CONNECT, cn);
    write_reg(CFG_CODE_DATA, dt);
    write_reg(CFG_CODE_ACK, ak);
  endtask

  // wait until every queued transaction is taken and answered
  task automatic settle();
    do @(negedge clk); while (accepted != queued || outcome_q.size() != 0);
    repeat (16) @(negedge clk);
  endtask

  function automatic logic [BYTE_W-1:0] pick_addr();
    return ($urandom_range(0, 7) == 0) ? BYTE_W'($urandom) : BYTE_W'($urandom_range(0, 3));
  endfunction

  task automatic queue_random(int n);
    int k;
    int r;
    int hit;
    int first;
    logic [BYTE_W-1:0] c;
    for (k = 0; k < n; k++) begin
      r = $urandom_range(0, 99);
      hit = -1;
      if (r >= 40 && r < 75) begin
        first = $urandom_range(0, SLOTS - 1);
        for (int j = 0; j < SLOTS; j++) begin
          if (hit < 0 && gen_table.valid[(first + j) % SLOTS]) begin
            hit = (first + j) % SLOTS;
          end
        end
      end
      if (r < 40) begin
        case ($urandom_range(0, 2))
          0: c = codes.live;
          1: c = codes.connect;
          default: c = codes.data;
        endcase
        queue_msg(FUNC_SEND, c, pick_addr(), pick_addr(),
                  ($urandom_range(0, 4) == 0) ? BYTE_W'($urandom) : '0);
      end else if (hit >= 0) begin
        queue_msg(FUNC_RECV, $urandom_range(0, 1) ? codes.ack : BYTE_W'($urandom),
                  ($urandom_range(0, 7) == 0) ? pick_addr() : gen_table.entry[hit].peer,
                  BYTE_W'($urandom), gen_table.entry[hit].tag);
      end else if (r < 85) begin
        queue_msg(FUNC_SEND, BYTE_W'($urandom), BYTE_W'($urandom), BYTE_W'($urandom),
                  ($urandom_range(0, 1) == 0) ? BYTE_W'($urandom) : '0);
      end else begin
        queue_msg(1'($urandom), BYTE_W'($urandom), BYTE_W'($urandom), BYTE_W'($urandom),
                  BYTE_W'($urandom));
      end
    end
  endtask

  always @(negedge clk) begin : driver
    msg_t m;
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_fire) begin
      if (msg_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        m = msg_q.pop_front();
        in_valid <= 1'b1;
        func <= m.func;
        cmd <= m.cmd;
        src_addr <= m.src;
        dst_addr <= m.dst;
        tag <= m.tag;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
  end

  always @(posedge clk) begin : monitor
    outcome_t got;
    outcome_t want;
    msg_t m;
    in_fire = !rst && in_valid && !in_stall;
    if (!rst && out_valid && !out_stall) begin
      got = {hdr_cmd, hdr_src, hdr_dst, hdr_tag, wait_tag, table_full, user_notify,
             conn_update, conn_local, conn_peer};
      if (outcome_q.size() == 0) begin
        report_mismatch("unexpected transaction", got.hdr_cmd, 0);
      end else begin
        want = outcome_q.pop_front();
        if (got.hdr_cmd != want.hdr_cmd) report_mismatch("hdr_cmd", got.hdr_cmd, want.hdr_cmd);
        if (got.hdr_src != want.hdr_src) report_mismatch("hdr_src", got.hdr_src, want.hdr_src);
        if (got.hdr_dst != want.hdr_dst) report_mismatch("hdr_dst", got.hdr_dst, want.hdr_dst);
        if (got.hdr_tag != want.hdr_tag) report_mismatch("hdr_tag", got.hdr_tag, want.hdr_tag);
        if (got.wait_tag != want.wait_tag) begin
          report_mismatch("wait_tag", got.wait_tag, want.wait_tag);
        end
        if (got.table_full !== want.table_full) begin
          report_mismatch("table_full", got.table_full, want.table_full);
        end
        if (got.user_notify !== want.user_notify) begin
          report_mismatch("user_notify", got.user_notify, want.user_notify);
        end
        if (got.conn_update != want.conn_update) begin
          report_mismatch("conn_update", got.conn_update, want.conn_update);
        end
        if (got.conn_local != want.conn_local) begin
          report_mismatch("conn_local", got.conn_local, want.conn_local);
        end
        if (got.conn_peer != want.conn_peer) begin
          report_mismatch("conn_peer", got.conn_peer, want.conn_peer);
        end
      end
    end
    if (in_fire) begin
      m = {func, cmd, src_addr, dst_addr, tag};
      chk_table = track_msg(chk_table, m, want);
      outcome_q.push_back(want);
      accepted++;
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles == LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  initial begin
    repeat (10) @(negedge clk);
    rst <= 1'b0;

    // reset codes: data, live retry, connect with explicit tag, plain send
    queue_msg(FUNC_SEND, RST_CODE_DATA, 8'h00, 8'hff, 8'h00);
    queue_msg(FUNC_SEND, RST_CODE_LIVE, 8'haa, 8'h55, 8'h00);
    queue_msg(FUNC_SEND, RST_CODE_LIVE, 8'haa, 8'h55, 8'h00);
    queue_msg(FUNC_SEND, RST_CODE_CONNECT, 8'h01, 8'h02, 8'h11);
    queue_msg(FUNC_SEND, 8'hff, 8'hff, 8'h00, 8'hff);
    // shared tag: lowest slot belongs to another peer, then live ack, connect ack
    queue_msg(FUNC_RECV, RST_CODE_ACK, 8'h02, 8'h00, 8'h03);
    queue_msg(FUNC_RECV, RST_CODE_ACK, 8'h55, 8'h00, 8'h03);
    queue_msg(FUNC_RECV, RST_CODE_ACK, 8'h02, 8'h00, 8'h03);
    queue_msg(FUNC_RECV, 8'h00, 8'hff, 8'hff, 8'h01);
    queue_msg(FUNC_RECV, RST_CODE_ACK, 8'h00, 8'h00, 8'hc8);
    // fill the table past its end
    for (int k = 0; k <= SLOTS; k++) begin
      queue_msg(FUNC_SEND, RST_CODE_DATA, 8'(k), 8'(k), 8'h00);
    end
    queue_msg(FUNC_SEND, RST_CODE_LIVE, 8'h07, 8'h07, 8'h00);
    queue_msg(FUNC_RECV, RST_CODE_ACK, 8'h00, 8'h00, 8'h04);
    // live and connect sends, each followed by a non-ack reply that frees no slot
    queue_msg(FUNC_SEND, RST_CODE_LIVE, 8'h03, 8'h04, 8'h00);
    queue_msg(FUNC_RECV, 8'h00, 8'h04, 8'h00, 8'h0d);
    queue_msg(FUNC_SEND, RST_CODE_CONNECT, 8'h09, 8'h08, 8'h00);
    queue_msg(FUNC_RECV, 8'h07, 8'h08, 8'h00, 8'h0e);
    settle();

    // tag counter pinned at zero
    write_reg(CFG_MAX_TAG, 8'h00);
    queue_msg(FUNC_SEND, codes.data, 8'h05, 8'h06, 8'h00);
    queue_msg(FUNC_SEND, codes.data, 8'h05, 8'h06, 8'h00);
    queue_msg(FUNC_RECV, codes.ack, 8'h06, 8'h00, 8'h00);
    settle();

    write_codes(8'd3, 8'h21, 8'h42, 8'h84, 8'h18);
    queue_random(85);
    settle();
    queue_random(85);
    settle();

    // live, connect and data share one code
    send_idle_pct = 64;
    recv_stall_pct = 15;
    write_codes(8'd1, 8'h5a, 8'h5a, 8'h5a, 8'h00);
    queue_random(170);
    settle();

    send_idle_pct = 0;
    recv_stall_pct = 0;
    write_codes(8'd255, 8'hff, 8'h00, 8'h80, 8'hff);
    queue_random(170);
    settle();

    if (outcome_q.size() != 0) begin
      report_mismatch("leftover transactions", outcome_q.size(), 0);
    end
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/prt_pkg.sv
rtl/prt_ram.sv
rtl/prt_ctrl.sv
rtl/prt_datapath.sv
rtl/pending_request_tracker.sv
test/tb_top.sv
